// File: rtl/core/upn_pkg.sv
// ----------------------------------------------------------------------------
// upn_pkg
// Shared types and character constants for the URL path normalizer.
// ----------------------------------------------------------------------------
package upn_pkg;

	localparam int MAX_RES = 4;
	localparam int RES_CW  = 3;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Results caused by one accepted item; last_idx is the index of the final one.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [1:0]              last_idx;
		logic                    has;
		logic                    last;
	} upn_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} upn_qstat_t;

endpackage

// File: rtl/core/upn_front.sv
// ----------------------------------------------------------------------------
// upn_front
// Accepts path bytes, tracks escape and slash state, and expands each item
// into its list of output bytes for the queue.
// ----------------------------------------------------------------------------
module upn_front import upn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] path_byte,
	input  logic       last_byte,
	input  logic       empty_path,
	input  upn_qstat_t qstat,
	output logic       push,
	output upn_entry_t push_data
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_DIG
	} phase_t;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [RES_CW-1:0]       n;
		logic                    slash;
		logic                    started;
	} work_t;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic       slash_q, started_q;
	work_t      w;
	logic       bare;
	logic       end_path;
	logic       accept;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return c[6] ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

	function automatic work_t emit(input work_t wi, input logic [7:0] b);
		work_t wo;
		wo = wi;
		if (wo.n < RES_CW'(MAX_RES)) begin
			wo.bytes[wo.n[1:0]] = b;
			wo.n = wo.n + RES_CW'(1);
		end
		return wo;
	endfunction

	// slash collapsing and leading-slash insertion
	function automatic work_t put_dec(input work_t wi, input logic [7:0] c);
		work_t wo;
		wo = wi;
		if (c == CH_SLASH) begin
			wo.slash = 1'b1;
		end else begin
			if (wo.slash || !wo.started) begin
				wo = emit(wo, CH_SLASH);
			end
			wo.slash   = 1'b0;
			wo         = emit(wo, c);
			wo.started = 1'b1;
		end
		return wo;
	endfunction

	function automatic work_t scan(input work_t wi, input logic [7:0] c);
		work_t wo;
		wo = wi;
		if (c == CH_PLUS) begin
			wo = put_dec(wo, CH_SPACE);
		end else if (c != CH_PCT) begin
			wo = put_dec(wo, c);
		end
		return wo;
	endfunction

	function automatic phase_t scan_phase(input logic [7:0] c);
		return (c == CH_PCT) ? PH_PCT : PH_IDLE;
	endfunction

	always_comb begin
		w         = '0;
		w.slash   = slash_q;
		w.started = started_q;
		phase_d   = phase_q;
		held_d    = held_q;
		bare      = 1'b0;
		if (!empty_path) begin
			case (phase_q)
				PH_PCT: begin
					if (is_hex(path_byte)) begin
						held_d  = path_byte;
						phase_d = PH_DIG;
					end else begin
						w       = put_dec(w, CH_PCT);
						w       = scan(w, path_byte);
						phase_d = scan_phase(path_byte);
					end
				end
				PH_DIG: begin
					if (is_hex(path_byte)) begin
						w       = put_dec(w, {hex_val(held_q), hex_val(path_byte)});
						phase_d = PH_IDLE;
					end else begin
						w       = put_dec(w, CH_PCT);
						w       = put_dec(w, held_q);
						w       = scan(w, path_byte);
						phase_d = scan_phase(path_byte);
					end
				end
				default: begin
					w       = scan(w, path_byte);
					phase_d = scan_phase(path_byte);
				end
			endcase
		end
		end_path = empty_path || last_byte;
		if (end_path) begin
			if (phase_d == PH_PCT) begin
				w = put_dec(w, CH_PCT);
			end else if (phase_d == PH_DIG) begin
				w = put_dec(w, CH_PCT);
				w = put_dec(w, held_d);
			end
			if (!w.started) begin
				w = emit(w, CH_SLASH);
			end
			if (w.n == '0) begin
				bare = 1'b1;
				w    = emit(w, CH_NUL);
			end
		end
	end

	assign in_stall = qstat.full;
	assign accept   = in_valid && !qstat.full;
	assign push     = accept && (w.n != '0);

	assign push_data.bytes    = w.bytes;
	assign push_data.last_idx = w.n[1:0] - 2'd1;
	assign push_data.has      = !bare;
	assign push_data.last     = end_path;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			held_q    <= '0;
			slash_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (accept) begin
			if (end_path) begin
				phase_q   <= PH_IDLE;
				held_q    <= '0;
				slash_q   <= 1'b0;
				started_q <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				held_q    <= held_d;
				slash_q   <= w.slash;
				started_q <= w.started;
			end
		end
	end

endmodule

// File: rtl/core/upn_queue.sv
// ----------------------------------------------------------------------------
// upn_queue
// Short FIFO of expanded entries between the front and back parts.
// ----------------------------------------------------------------------------
module upn_queue import upn_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  upn_entry_t push_data,
	input  logic       pop,
	output upn_entry_t head,
	output upn_qstat_t qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	upn_entry_t    mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/upn_back.sv
// ----------------------------------------------------------------------------
// upn_back
// Walks the head entry one result per cycle into the output register, unless out_stall holds it.
// ----------------------------------------------------------------------------
module upn_back import upn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  upn_entry_t head,
	input  upn_qstat_t qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       last_out
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load   = !qstat.empty && (!out_valid_q || !out_stall);
	assign at_end = (idx_q == head.last_idx);
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.bytes[idx_q];
			has_q      <= head.has;
			last_q     <= head.last && at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_q;
	assign last_out  = last_q;

endmodule

// File: rtl/core/url_path_normalizer.sv
// ----------------------------------------------------------------------------
// url_path_normalizer
// Streaming URL path normalizer: percent decoding, '+' to space, slash
// collapsing, trailing slash removal and leading slash insertion.
// ----------------------------------------------------------------------------
// The block takes one path byte per cycle while in_stall is low, and the front
// part expands it at once into the zero to four output bytes it causes; the
// back part drives one output byte per cycle from the output register while
// out_stall is low. A byte that yields several output bytes occupies the output
// side for longer; the QUEUE_DEPTH entry queue between the two parts absorbs
// such bursts before in_stall rises. An accepted byte is written to the queue
// and from there loaded into the output register. An end of path with nothing
// left to emit gives a bare end marker (has_byte 0).
module url_path_normalizer import upn_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] path_byte,
	input  logic       last_byte,
	input  logic       empty_path,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       last_out
);

	upn_qstat_t qstat;
	upn_entry_t push_data;
	upn_entry_t head;
	logic       push;
	logic       pop;

	upn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.path_byte  (path_byte),
		.last_byte  (last_byte),
		.empty_path (empty_path),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	upn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	upn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.last_out  (last_out)
	);

	// a bare end marker is always the final result of its path
	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> last_out)
		else $error("bare end marker without last_out");

	// an empty path on an idle block reaches the output through the queue and the output register
	a_empty_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && empty_path && qstat.empty && !out_valid
		|-> ##2 out_valid)
		else $error("empty path result missing");

	// output register drains when nothing is queued
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && qstat.empty |=> !out_valid)
		else $error("output valid without a queued entry");

	// nothing is popped from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue underflow");

endmodule
